// ===== sv/twbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbb_pkg
// Shared types and constants for the two-wire byte bit-bang engine.
// ----------------------------------------------------------------------------
package twbb_pkg;

	// configuration space
	localparam int          PADDR_W     = 3;
	localparam int          DATA_W      = 32;
	localparam int          DELAY_W     = 10;
	localparam logic        REG_DELAY   = 1'b0;
	localparam logic [9:0]  DELAY_RESET = 10'd5;
	localparam logic [9:0]  MIN_DELAY   = 10'd1;
	localparam logic [9:0]  MAX_DELAY   = 10'd1000;

	// acknowledge handling after a read byte
	localparam logic [1:0]  ACK_NONE    = 2'd0;
	localparam logic [1:0]  ACK_SEND    = 2'd1;
	localparam logic [1:0]  ACK_INVALID = 2'd3;

	typedef enum logic [2:0] {
		ACT_TICK    = 3'd0,
		ACT_SET_SCL = 3'd1,
		ACT_SET_SDA = 3'd2,
		ACT_GET_SDA = 3'd3,
		ACT_WRITE   = 3'd4,
		ACT_READ    = 3'd5
	} action_t;

	// classified command, produced by the front end
	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_SET_SCL,
		CMD_SET_SDA,
		CMD_GET_SDA,
		CMD_WRITE,
		CMD_READ,
		CMD_BAD
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_SCL  = 3'd1,
		MODE_SDA  = 3'd2,
		MODE_WR   = 3'd4,
		MODE_RD   = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		PH_SDA = 3'd0,
		PH_HI  = 3'd1,
		PH_LO  = 3'd2,
		PH_REL = 3'd3,
		PH_AHI = 3'd4,
		PH_ALO = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NAK  = 2'd1,
		ST_BAD  = 2'd2,
		ST_BUSY = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] value;
		logic       nak_ok;
		logic [1:0] ack_mode;
		logic       sda_in;
	} in_word_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] read_data;
		logic       sda_level;
	} out_word_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] value;
		logic       nak_ok;
		logic [1:0] ack_mode;
		logic       sda_in;
	} cmd_word_t;

endpackage

// ===== sv/twbb_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbb_fifo
// Small register queue with push/full and pop/empty sides. DEPTH >= 2.
// ----------------------------------------------------------------------------
module twbb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fifo count above depth");

endmodule

// ===== sv/twbb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbb_front
// Input stage: takes words, decodes the action and screens bad values.
// ----------------------------------------------------------------------------
module twbb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  twbb_pkg::in_word_t   item,
	output logic                 full,
	output logic                 q_push,
	output twbb_pkg::cmd_word_t  q_word,
	input  logic                 q_full
);

	logic                valid_s1;
	twbb_pkg::cmd_word_t word_s1;
	twbb_pkg::cmd_t      cls;
	logic                accept;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_word = word_s1;

	always_comb begin
		case (item.action)
			twbb_pkg::ACT_SET_SCL: begin
				cls = (item.value > 8'd1) ? twbb_pkg::CMD_BAD : twbb_pkg::CMD_SET_SCL;
			end
			twbb_pkg::ACT_SET_SDA: begin
				cls = (item.value > 8'd1) ? twbb_pkg::CMD_BAD : twbb_pkg::CMD_SET_SDA;
			end
			twbb_pkg::ACT_GET_SDA: cls = twbb_pkg::CMD_GET_SDA;
			twbb_pkg::ACT_WRITE:   cls = twbb_pkg::CMD_WRITE;
			twbb_pkg::ACT_READ: begin
				cls = (item.ack_mode == twbb_pkg::ACK_INVALID) ?
					twbb_pkg::CMD_BAD : twbb_pkg::CMD_READ;
			end
			twbb_pkg::ACT_TICK:    cls = twbb_pkg::CMD_TICK;
			// unused action codes run as plain ticks
			default:               cls = twbb_pkg::CMD_TICK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.cmd      <= cls;
			word_s1.value    <= item.value;
			word_s1.nak_ok   <= item.nak_ok;
			word_s1.ack_mode <= item.ack_mode;
			word_s1.sda_in   <= item.sda_in;
		end
	end

endmodule

// ===== sv/twbb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twbb_back
// Waveform engine: runs one word per unstalled cycle against pin state.
// ----------------------------------------------------------------------------
module twbb_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [twbb_pkg::DELAY_W-1:0] delay_ticks,
	input  logic                      q_empty,
	input  twbb_pkg::cmd_word_t       q_word,
	output logic                      q_pop,
	input  logic                      o_full,
	output logic                      o_push,
	output twbb_pkg::out_word_t       o_word
);

	localparam int SETTLE_STEPS = 3;

	typedef struct packed {
		logic              scl;
		logic              sda;
		twbb_pkg::mode_t   mode;
		twbb_pkg::phase_t  phase;
		logic [3:0]        bidx;
		logic [7:0]        shift;
		logic [9:0]        wcnt;
		logic [1:0]        pack;
		logic              nign;
		logic              nakerr;
		logic [7:0]        rdreg;
	} eng_t;

	localparam eng_t ENG_RST = '{
		scl: 1'b1, sda: 1'b1, mode: twbb_pkg::MODE_IDLE, phase: twbb_pkg::PH_SDA,
		bidx: 4'd0, shift: 8'd0, wcnt: 10'd0, pack: 2'd0,
		nign: 1'b0, nakerr: 1'b0, rdreg: 8'd0};

	function automatic logic [9:0] half_up(logic [9:0] d);
		logic [10:0] t;
		t = {1'b0, d} + 11'd1;
		return t[10:1];
	endfunction

	// start a phase: drive its pin and load its wait
	function automatic eng_t enter(eng_t s, twbb_pkg::phase_t ph, logic lvl,
			logic [9:0] d);
		eng_t r;
		r       = s;
		r.phase = ph;
		case (ph)
			twbb_pkg::PH_SDA: begin
				r.sda  = lvl;
				r.wcnt = half_up(d);
			end
			twbb_pkg::PH_REL: begin
				r.sda  = 1'b1;
				r.wcnt = half_up(d);
			end
			twbb_pkg::PH_HI, twbb_pkg::PH_AHI: begin
				r.scl  = 1'b1;
				r.wcnt = d;
			end
			default: begin
				r.scl = 1'b0;
				// low time between read bits is a full unit
				if (ph == twbb_pkg::PH_LO && s.mode == twbb_pkg::MODE_RD && s.bidx < 4'd8) begin
					r.wcnt = d;
				end else begin
					r.wcnt = d >> 1;
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic finishes(eng_t s);
		logic f;
		f = 1'b1;
		case (s.mode)
			twbb_pkg::MODE_WR: begin
				f = !(s.phase inside {twbb_pkg::PH_SDA, twbb_pkg::PH_HI, twbb_pkg::PH_LO,
					twbb_pkg::PH_REL, twbb_pkg::PH_AHI});
			end
			twbb_pkg::MODE_RD: begin
				if (s.phase == twbb_pkg::PH_LO) begin
					f = (s.bidx >= 4'd8) && (s.pack == twbb_pkg::ACK_NONE);
				end else begin
					f = !(s.phase inside {twbb_pkg::PH_REL, twbb_pkg::PH_HI,
						twbb_pkg::PH_SDA, twbb_pkg::PH_AHI});
				end
			end
			default: f = 1'b1;
		endcase
		return f;
	endfunction

	function automatic eng_t advance(eng_t s, logic sda_in, logic [9:0] d);
		eng_t r;
		r = s;
		if (s.mode == twbb_pkg::MODE_WR) begin
			case (s.phase)
				twbb_pkg::PH_SDA: r = enter(s, twbb_pkg::PH_HI, 1'b0, d);
				twbb_pkg::PH_HI:  r = enter(s, twbb_pkg::PH_LO, 1'b0, d);
				twbb_pkg::PH_LO: begin
					r.bidx = s.bidx + 4'd1;
					if (r.bidx < 4'd8) begin
						r = enter(r, twbb_pkg::PH_SDA, s.shift[3'd7 - r.bidx[2:0]], d);
					end else begin
						r = enter(r, twbb_pkg::PH_REL, 1'b1, d);
					end
				end
				twbb_pkg::PH_REL: r = enter(s, twbb_pkg::PH_AHI, 1'b0, d);
				twbb_pkg::PH_AHI: begin
					// ack sampled at the end of the high time
					if (sda_in && !s.nign) begin
						r.nakerr = 1'b1;
					end
					r = enter(r, twbb_pkg::PH_ALO, 1'b0, d);
				end
				default: r = s;
			endcase
		end else if (s.mode == twbb_pkg::MODE_RD) begin
			case (s.phase)
				twbb_pkg::PH_REL: r = enter(s, twbb_pkg::PH_HI, 1'b0, d);
				twbb_pkg::PH_HI: begin
					r.shift = {s.shift[6:0], sda_in};
					r.bidx  = s.bidx + 4'd1;
					r       = enter(r, twbb_pkg::PH_LO, 1'b0, d);
				end
				twbb_pkg::PH_LO: begin
					if (s.bidx < 4'd8) begin
						r = enter(s, twbb_pkg::PH_HI, 1'b0, d);
					end else begin
						r = enter(s, twbb_pkg::PH_SDA, (s.pack == twbb_pkg::ACK_SEND) ? 1'b0 : 1'b1, d);
					end
				end
				twbb_pkg::PH_SDA: r = enter(s, twbb_pkg::PH_AHI, 1'b0, d);
				twbb_pkg::PH_AHI: r = enter(s, twbb_pkg::PH_ALO, 1'b0, d);
				default:          r = s;
			endcase
		end
		return r;
	endfunction

	eng_t              eng_q;
	eng_t              nxt;
	logic [9:0]        d;
	logic              busy;
	logic              done;
	logic              fin;
	logic              lvl;
	twbb_pkg::status_t st;

	always_comb begin
		if (delay_ticks < twbb_pkg::MIN_DELAY) begin
			d = twbb_pkg::MIN_DELAY;
		end else if (delay_ticks > twbb_pkg::MAX_DELAY) begin
			d = twbb_pkg::MAX_DELAY;
		end else begin
			d = delay_ticks;
		end
	end

	assign q_pop  = !q_empty && !o_full;
	assign o_push = q_pop;

	always_comb begin
		nxt  = eng_q;
		done = 1'b0;
		fin  = 1'b0;
		lvl  = 1'b0;
		st   = twbb_pkg::ST_OK;
		busy = (eng_q.mode != twbb_pkg::MODE_IDLE);
		if (busy && q_word.cmd != twbb_pkg::CMD_TICK) begin
			st = twbb_pkg::ST_BUSY;
		end else begin
			case (q_word.cmd)
				twbb_pkg::CMD_BAD: begin
					st   = twbb_pkg::ST_BAD;
					done = 1'b1;
				end
				twbb_pkg::CMD_SET_SCL: begin
					nxt.mode  = twbb_pkg::MODE_SCL;
					nxt.scl   = q_word.value[0];
					nxt.wcnt  = q_word.value[0] ? d : (d >> 1);
					nxt.phase = twbb_pkg::PH_SDA;
				end
				twbb_pkg::CMD_SET_SDA: begin
					nxt.mode  = twbb_pkg::MODE_SDA;
					nxt.sda   = q_word.value[0];
					nxt.wcnt  = half_up(d);
					nxt.phase = twbb_pkg::PH_SDA;
				end
				twbb_pkg::CMD_GET_SDA: begin
					done = 1'b1;
					lvl  = q_word.sda_in;
				end
				twbb_pkg::CMD_WRITE: begin
					nxt.mode   = twbb_pkg::MODE_WR;
					nxt.shift  = q_word.value;
					nxt.bidx   = 4'd0;
					nxt.nign   = q_word.nak_ok;
					nxt.nakerr = 1'b0;
					nxt        = enter(nxt, twbb_pkg::PH_SDA, q_word.value[7], d);
				end
				twbb_pkg::CMD_READ: begin
					nxt.mode   = twbb_pkg::MODE_RD;
					nxt.pack   = q_word.ack_mode;
					nxt.shift  = 8'd0;
					nxt.bidx   = 4'd0;
					nxt.nakerr = 1'b0;
					nxt        = enter(nxt, twbb_pkg::PH_REL, 1'b1, d);
				end
				default: begin
					if (busy && nxt.wcnt != 10'd0) begin
						nxt.wcnt = nxt.wcnt - 10'd1;
					end
				end
			endcase
		end
		// zero-length waits chain through at most two phases and a finish
		for (int i = 0; i < SETTLE_STEPS; i++) begin
			if (nxt.mode != twbb_pkg::MODE_IDLE && nxt.wcnt == 10'd0) begin
				if (finishes(nxt)) begin
					if (nxt.mode == twbb_pkg::MODE_RD) begin
						nxt.rdreg = nxt.shift;
					end
					nxt.mode = twbb_pkg::MODE_IDLE;
					fin      = 1'b1;
				end else begin
					nxt = advance(nxt, q_word.sda_in, d);
				end
			end
		end
		if (fin) begin
			done       = 1'b1;
			st         = nxt.nakerr ? twbb_pkg::ST_NAK : twbb_pkg::ST_OK;
			nxt.nakerr = 1'b0;
		end
	end

	assign o_word.scl_out   = nxt.scl;
	assign o_word.sda_out   = nxt.sda;
	assign o_word.busy_res  = (nxt.mode != twbb_pkg::MODE_IDLE);
	assign o_word.done_res  = done;
	assign o_word.status    = st;
	assign o_word.read_data = nxt.rdreg;
	assign o_word.sda_level = lvl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q <= ENG_RST;
		end else if (q_pop) begin
			eng_q <= nxt;
		end
	end

	a_wait_live: assert property (@(posedge clk) disable iff (!arst_n)
		(eng_q.mode != twbb_pkg::MODE_IDLE) |-> (eng_q.wcnt != 10'd0))
		else $error("busy with an expired wait");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eng_q.mode == twbb_pkg::MODE_WR || eng_q.mode == twbb_pkg::MODE_RD)
		|-> (eng_q.bidx <= 4'd8))
		else $error("bit index past the byte");

	a_nak_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(eng_q.mode == twbb_pkg::MODE_IDLE) |-> !eng_q.nakerr)
		else $error("nak flag left set while idle");

	a_busy_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(o_push && o_word.status == twbb_pkg::ST_BUSY)
		|-> (!o_word.done_res && o_word.busy_res))
		else $error("busy reject with done or idle engine");

endmodule

// ===== sv/two_wire_byte_bitbang_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wire_byte_bitbang_engine
// Open-drain two-wire master that bit-bangs bytes, paced by tick words.
// ----------------------------------------------------------------------------
// Usage:
//   Command words enter through push/full; each one is a tick (carrying the
//   sampled SDA level) or a pin/byte command. Every accepted word produces
//   exactly one result word on the empty/pop side, showing the pin drive
//   levels, busy/done, status, last read byte and the echoed SDA level.
//   delay_ticks (APB, address 0) sets the bit period unit in ticks.
// Timing:
//   One word per cycle sustained while the result queue is popped. A result
//   passes through the decode register and the command queue into the
//   waveform engine, which handles each word combinationally (including
//   chains of zero-length phases), and on into the result queue.
// Reset:
//   Both lines are released, no command is running, delay_ticks is 5 and
//   both queues are empty.
// Stall:
//   While pop is held low the result queue fills, the engine stops, the
//   command queue fills and full rises. Nothing is dropped.
// ----------------------------------------------------------------------------
module two_wire_byte_bitbang_engine #(
	parameter int CMD_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  twbb_pkg::in_word_t               item,
	output logic                             full,
	output logic                             empty,
	input  logic                             pop,
	output twbb_pkg::out_word_t              result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [twbb_pkg::PADDR_W-1:0]     paddr,
	input  logic [twbb_pkg::DATA_W-1:0]      pwdata,
	output logic [twbb_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);

	logic [twbb_pkg::DELAY_W-1:0] delay_q;
	logic                         reg_idx;
	logic                         cfg_wr;

	twbb_pkg::cmd_word_t          f_word;
	logic                         f_push;
	logic                         cq_full;
	twbb_pkg::cmd_word_t          cq_word;
	logic                         cq_empty;
	logic                         cq_pop;
	twbb_pkg::out_word_t          b_word;
	logic                         b_push;
	logic                         rq_full;

	// register file: one word per 4 bytes
	assign pready  = 1'b1;
	assign reg_idx = paddr[twbb_pkg::PADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == twbb_pkg::REG_DELAY) ?
		twbb_pkg::DATA_W'(delay_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= twbb_pkg::DELAY_RESET;
		end else if (cfg_wr && reg_idx == twbb_pkg::REG_DELAY) begin
			delay_q <= pwdata[twbb_pkg::DELAY_W-1:0];
		end
	end

	twbb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.q_push (f_push),
		.q_word (f_word),
		.q_full (cq_full)
	);

	twbb_fifo #(
		.WIDTH ($bits(twbb_pkg::cmd_word_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_word),
		.full   (cq_full),
		.pop    (cq_pop),
		.rdata  (cq_word),
		.empty  (cq_empty)
	);

	twbb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.delay_ticks (delay_q),
		.q_empty     (cq_empty),
		.q_word      (cq_word),
		.q_pop       (cq_pop),
		.o_full      (rq_full),
		.o_push      (b_push),
		.o_word      (b_word)
	);

	twbb_fifo #(
		.WIDTH ($bits(twbb_pkg::out_word_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_push),
		.wdata  (b_word),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
